// File: design/gme_pkg.sv
// gme_pkg: shared types and constants for the Gram matrix engine.
// No dependencies.
`default_nettype none
package gme_pkg;
	typedef enum logic {OP_LOAD = 1'b0, OP_READ = 1'b1} opcode_t;
	typedef enum logic {REG_ROWS = 1'b0, REG_COLS = 1'b1} reg_index_t;
	localparam int ELEM_W = 16;
	localparam int ACC_W = 48;
	localparam int ROWS_W = 9;
	localparam int COLS_W = 5;
	// control word from sequencer into the cell chain
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: design/gme_cell.sv
// gme_cell: one multiply-accumulate cell; forwards the row operand to its neighbor.
// Depends on gme_pkg.
`default_nettype none
module gme_cell (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gme_pkg::cell_ctl_t                   ctl_in,
	input  wire logic signed [gme_pkg::ELEM_W-1:0]    a_in,
	input  wire logic signed [gme_pkg::ELEM_W-1:0]    b,
	output gme_pkg::cell_ctl_t                        ctl_out,
	output logic signed [gme_pkg::ELEM_W-1:0]         a_out,
	output logic signed [gme_pkg::ACC_W-1:0]          acc,
	output logic                                      done
);
	logic signed [2*gme_pkg::ELEM_W-1:0] prod_s1;
	gme_pkg::cell_ctl_t ctl_s1;
	logic signed [gme_pkg::ACC_W-1:0] acc_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_out <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_out <= ctl_in;
			done_q <= ctl_s1.valid && ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		a_out <= a_in;
		prod_s1 <= (2*gme_pkg::ELEM_W)'(a_in) * (2*gme_pkg::ELEM_W)'(b);
		if (ctl_s1.valid) begin
			if (ctl_s1.first) acc_q <= gme_pkg::ACC_W'(prod_s1);
			else acc_q <= acc_q + gme_pkg::ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;
	assign done = done_q;
endmodule
`default_nettype wire

// File: design/gme_chain.sv
// gme_chain: row of MAX_COLS cells; cell j accumulates column i dot column j.
// Depends on gme_pkg, gme_cell.
`default_nettype none
module gme_chain #(
	parameter int MAX_COLS = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire gme_pkg::cell_ctl_t                       ctl_in,
	input  wire logic signed [gme_pkg::ELEM_W-1:0]        a_in,
	input  wire logic signed [MAX_COLS*gme_pkg::ELEM_W-1:0] b_row,
	output logic signed [MAX_COLS*gme_pkg::ACC_W-1:0]     acc_row,
	output logic                                          done
);
	gme_pkg::cell_ctl_t ctl [MAX_COLS+1];
	logic signed [gme_pkg::ELEM_W-1:0] a [MAX_COLS+1];
	logic [MAX_COLS-1:0] dn;
	assign ctl[0] = ctl_in;
	assign a[0] = a_in;
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		// lane c passes through c delay registers so it meets the row operand walking down the chain
		logic signed [gme_pkg::ELEM_W-1:0] b_sk;
		if (c == 0) begin : g_nodly
			assign b_sk = b_row[gme_pkg::ELEM_W-1:0];
		end else begin : g_dly
			logic signed [gme_pkg::ELEM_W-1:0] b_dly_q [c];
			always_ff @(posedge clk) begin
				b_dly_q[0] <= b_row[c*gme_pkg::ELEM_W +: gme_pkg::ELEM_W];
				for (int t = 1; t < c; t++)
					b_dly_q[t] <= b_dly_q[t-1];
			end
			assign b_sk = b_dly_q[c-1];
		end
		gme_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl_in(ctl[c]), .a_in(a[c]),
			.b(b_sk),
			.ctl_out(ctl[c+1]), .a_out(a[c+1]),
			.acc(acc_row[c*gme_pkg::ACC_W +: gme_pkg::ACC_W]), .done(dn[c])
		);
	end
	assign done = dn[MAX_COLS-1];
endmodule
`default_nettype wire

// File: design/gram_matrix_engine_unit.sv
// gram_matrix_engine_unit: X = A^T A engine top level.
// Depends on gme_pkg, gme_chain, gme_cell.
//
// Usage: set row_count (index 0) and col_count (index 1) on the cfg channel while
// idle; any write restarts loading. Send m*n load words (opcode 0), column-major.
// Loads take one per cycle while no cfg write is pending. Each row r of A is
// stored as one wide word holding all columns. After the last load the block is
// busy (in_ready low) for n passes: pass i streams column i down the cell chain,
// cell j pairing it with the stored row word, so row i of X lands in one wide
// result word at the pass end. Read words (opcode 1) then give X column-major,
// one per cycle while results are accepted; result_last marks entry n*n-1. A read
// before X is complete returns zero with not_ready. The output register holds one
// result; while it is unaccepted a further read waits, loads still pass. Reset
// clears counters and result_ready; stores are not cleared.
`default_nettype none
module gram_matrix_engine_unit #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   opcode,
	input  wire logic signed [gme_pkg::ELEM_W-1:0]      element,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [gme_pkg::ACC_W-1:0]            gram_value,
	output logic                                        result_last,
	output logic                                        not_ready,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic                                   cfg_index,
	input  wire logic [gme_pkg::ROWS_W-1:0]             cfg_data
);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int EW = gme_pkg::ELEM_W;
	localparam int AW = gme_pkg::ACC_W;
	localparam int DRAIN = MAX_COLS + 4;

	typedef enum logic [1:0] {ST_RUN, ST_FEED, ST_WAIT} state_t;
	state_t state_q;

	logic [gme_pkg::ROWS_W-1:0] row_cfg_q;
	logic [gme_pkg::COLS_W-1:0] col_cfg_q;
	logic [RW:0] m_eff;
	logic [CNW-1:0] n_eff;
	always_comb begin
		if (row_cfg_q == '0) m_eff = (RW+1)'(1);
		else if (32'(row_cfg_q) > MAX_ROWS) m_eff = (RW+1)'(MAX_ROWS);
		else m_eff = (RW+1)'(row_cfg_q);
		if (col_cfg_q == '0) n_eff = CNW'(1);
		else if (32'(col_cfg_q) > MAX_COLS) n_eff = CNW'(MAX_COLS);
		else n_eff = CNW'(col_cfg_q);
	end

	// matrix store: one word per row; column lanes written by byte-enable style
	logic [EW-1:0] mstore [MAX_ROWS][MAX_COLS];
	logic [AW-1:0] rstore [MAX_COLS][MAX_COLS];

	logic [RW:0] ld_row_q;
	logic [CNW-1:0] ld_col_q;
	logic ready_q;
	logic [CW:0] rd_row_q, rd_col_q;
	logic [CNW-1:0] pass_q;
	logic [RW:0] k_q;
	logic [$clog2(DRAIN+1)-1:0] dr_q;

	logic in_acc, cfg_acc, out_free, ld_acc, rd_acc;
	assign out_free = !out_valid || out_ready;
	// a pending cfg write takes the cycle; the input word waits
	assign in_ready = (state_q == ST_RUN) && !cfg_valid &&
		(opcode == gme_pkg::OP_LOAD || out_free);
	assign cfg_ready = (state_q == ST_RUN);
	assign in_acc = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign ld_acc = in_acc && opcode == gme_pkg::OP_LOAD;
	assign rd_acc = in_acc && opcode == gme_pkg::OP_READ;

	logic [RW:0] lr;
	logic [CNW-1:0] lc;
	always_comb begin
		lr = ready_q ? '0 : ld_row_q;
		lc = ready_q ? '0 : ld_col_q;
	end
	logic ld_end_row, ld_done;
	assign ld_end_row = (lr + 1'b1) == m_eff;
	assign ld_done = ld_end_row && (lc + 1'b1) == n_eff;

	// feed: row k of mstore to chain; a_in is column pass_q of row k
	gme_pkg::cell_ctl_t ctl_in;
	logic signed [EW-1:0] a_in;
	logic signed [MAX_COLS*EW-1:0] b_row;
	logic signed [MAX_COLS*AW-1:0] acc_row;
	logic chain_done;
	logic [MAX_COLS*EW-1:0] row_rd_s1;
	logic ctl_v_s1, ctl_f_s1, ctl_l_s1;

	always_ff @(posedge clk) begin
		if (ld_acc) mstore[lr[RW-1:0]][lc[CW-1:0]] <= element;
		for (int c = 0; c < MAX_COLS; c++)
			row_rd_s1[c*EW +: EW] <= mstore[k_q[RW-1:0]][c];
		if (chain_done)
			for (int c = 0; c < MAX_COLS; c++)
				rstore[pass_q[CW-1:0]][c] <= acc_row[c*AW +: AW];
	end
	assign b_row = row_rd_s1;
	always_comb begin
		a_in = '0;
		for (int c = 0; c < MAX_COLS; c++)
			if (c == 32'(pass_q)) a_in = row_rd_s1[c*EW +: EW];
		ctl_in.valid = ctl_v_s1;
		ctl_in.first = ctl_f_s1;
		ctl_in.last = ctl_l_s1;
	end

	gme_chain #(.MAX_COLS(MAX_COLS)) u_chain (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_in), .a_in(a_in), .b_row(b_row),
		.acc_row(acc_row), .done(chain_done)
	);

	logic rd_last;
	assign rd_last = (32'(rd_row_q) + 1 == 32'(n_eff)) && (32'(rd_col_q) + 1 == 32'(n_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			row_cfg_q <= gme_pkg::ROWS_W'(1);
			col_cfg_q <= gme_pkg::COLS_W'(1);
			ld_row_q <= '0; ld_col_q <= '0; ready_q <= 1'b0;
			rd_row_q <= '0; rd_col_q <= '0;
			pass_q <= '0; k_q <= '0; dr_q <= '0;
			ctl_v_s1 <= 1'b0; ctl_f_s1 <= 1'b0; ctl_l_s1 <= 1'b0;
			out_valid <= 1'b0; gram_value <= '0; result_last <= 1'b0; not_ready <= 1'b0;
		end else begin
			ctl_v_s1 <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_RUN: begin
					if (cfg_acc) begin
						if (cfg_index == gme_pkg::REG_ROWS) row_cfg_q <= cfg_data;
						else col_cfg_q <= cfg_data[gme_pkg::COLS_W-1:0];
						ld_row_q <= '0; ld_col_q <= '0; ready_q <= 1'b0;
						rd_row_q <= '0; rd_col_q <= '0;
					end else if (ld_acc) begin
						ready_q <= 1'b0;
						rd_row_q <= '0; rd_col_q <= '0;
						if (ld_done) begin
							ld_row_q <= '0; ld_col_q <= '0;
							pass_q <= '0; k_q <= '0;
							state_q <= ST_FEED;
						end else if (ld_end_row) begin
							ld_row_q <= '0; ld_col_q <= lc + 1'b1;
						end else begin
							ld_row_q <= lr + 1'b1; ld_col_q <= lc;
						end
					end else if (rd_acc) begin
						out_valid <= 1'b1;
						if (!ready_q) begin
							gram_value <= '0; result_last <= 1'b0; not_ready <= 1'b1;
						end else begin
							gram_value <= rstore[rd_col_q[CW-1:0]][rd_row_q[CW-1:0]];
							result_last <= rd_last; not_ready <= 1'b0;
							if (rd_last) begin
								rd_row_q <= '0; rd_col_q <= '0;
							end else if (32'(rd_row_q) + 1 == 32'(n_eff)) begin
								rd_row_q <= '0; rd_col_q <= rd_col_q + 1'b1;
							end else rd_row_q <= rd_row_q + 1'b1;
						end
					end
				end
				ST_FEED: begin
					ctl_v_s1 <= 1'b1;
					ctl_f_s1 <= (k_q == '0);
					ctl_l_s1 <= (k_q + 1'b1 == m_eff);
					if (k_q + 1'b1 == m_eff) begin
						k_q <= '0; dr_q <= '0; state_q <= ST_WAIT;
					end else k_q <= k_q + 1'b1;
				end
				ST_WAIT: begin
					dr_q <= dr_q + 1'b1;
					if (32'(dr_q) == DRAIN - 1) begin
						if (pass_q + 1'b1 == n_eff) begin
							ready_q <= 1'b1; state_q <= ST_RUN;
						end else begin
							pass_q <= pass_q + 1'b1; state_q <= ST_FEED;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule
`default_nettype wire
